// File: hw/rtl/rcws_pkg.sv
// ----------------------------------------------------------------------------
// rcws_pkg
// Shared constants and types for the raycast wall column shader.
// ----------------------------------------------------------------------------
package rcws_pkg;

    localparam int SCREEN_HEIGHT = 512;
    localparam int TILE          = 64;
    localparam int TILE_BITS     = $clog2(TILE);
    localparam int ANGLE_BITS    = 12;
    localparam int TEX_AW        = 14;
    localparam int DIST_W        = 24;
    localparam int NUM_W         = 16 + TILE_BITS + 8;
    localparam int MID_ROW       = SCREEN_HEIGHT / 2;

    localparam logic [DIST_W-1:0] HEIGHT_MAX = {DIST_W{1'b1}};

    localparam logic [1:0] CFG_CEILING = 2'd0;
    localparam logic [1:0] CFG_FLOOR   = 2'd1;
    localparam logic [1:0] CFG_VIEW    = 2'd2;
    localparam logic [1:0] CFG_PROJ    = 2'd3;

    typedef enum logic [1:0] {
        RGN_CEILING = 2'd0,
        RGN_WALL    = 2'd1,
        RGN_FLOOR   = 2'd2
    } region_t;

    typedef struct packed {
        logic                 is_pix;
        logic [9:0]           column;
        logic [8:0]           row;
        logic [1:0]           tex_sel;
        logic [TILE_BITS-1:0] tex_x;
        logic [TEX_AW-1:0]    waddr;
        logic [31:0]          wdata;
    } side_t;

endpackage

// File: hw/rtl/rcws_div.sv
// ----------------------------------------------------------------------------
// rcws_div
// Pipelined restoring divider, one quotient bit per stage. The starting
// remainder must be below the divisor.
// ----------------------------------------------------------------------------
module rcws_div #(
    parameter int DEN_W  = 24,
    parameter int QUO_W  = 24,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DEN_W-1:0]  in_rem,
    input  logic [QUO_W-1:0]  in_low,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [QUO_W-1:0]  out_quo,
    output logic [SIDE_W-1:0] out_side
);

    logic [DEN_W-1:0]  rem_reg  [QUO_W];
    logic [QUO_W-1:0]  low_reg  [QUO_W];
    logic [QUO_W-1:0]  quo_reg  [QUO_W];
    logic [DEN_W-1:0]  den_reg  [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];
    logic              valid_reg [QUO_W];

    genvar i;
    generate
        for (i = 0; i < QUO_W; i++)
        begin : g_stage
            logic [DEN_W-1:0]  rem_in;
            logic [QUO_W-1:0]  low_in;
            logic [QUO_W-1:0]  quo_in;
            logic [DEN_W-1:0]  den_in;
            logic [SIDE_W-1:0] side_in;
            logic              valid_in;
            logic [DEN_W:0]    sh;
            logic              ge;
            logic [DEN_W-1:0]  rem_next;

            if (i == 0)
            begin : g_first
                assign rem_in   = in_rem;
                assign low_in   = in_low;
                assign quo_in   = '0;
                assign den_in   = in_den;
                assign side_in  = in_side;
                assign valid_in = in_valid;
            end
            else
            begin : g_rest
                assign rem_in   = rem_reg[i-1];
                assign low_in   = low_reg[i-1];
                assign quo_in   = quo_reg[i-1];
                assign den_in   = den_reg[i-1];
                assign side_in  = side_reg[i-1];
                assign valid_in = valid_reg[i-1];
            end

            assign sh       = {rem_in, low_in[QUO_W-1]};
            assign ge       = (sh >= {1'b0, den_in});
            assign rem_next = ge ? DEN_W'(sh - {1'b0, den_in}) : sh[DEN_W-1:0];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[i] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[i] <= valid_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i]  <= rem_next;
                    low_reg[i]  <= {low_in[QUO_W-2:0], 1'b0};
                    quo_reg[i]  <= {quo_in[QUO_W-2:0], ge};
                    den_reg[i]  <= den_in;
                    side_reg[i] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

// File: hw/rtl/raycast_wall_column_shader_top.sv
// ----------------------------------------------------------------------------
// raycast_wall_column_shader_top
// Fisheye-corrected wall slice shader with a 16K-word texel store.
// Throughput: one transaction per cycle; the pipeline halts only while a
// finished result is held by the output register and not taken.
// Reset clears valids and the colour and view-angle registers, and sets the projection distance to 887; the texel
// store is not cleared.
module raycast_wall_column_shader_top (
    input  logic         clk,
    input  logic         rst_n,
    // tdata: column, row, hit_distance, ray_dir, coord, is_horizontal,
    //        north_face, west_face, texel_index, texel_color
    input  logic [119:0] s_axis_tdata,
    // tuser: req_type
    input  logic         s_axis_tuser,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: pixel_color, column_out, row_out, zero pad
    output logic [55:0]  m_axis_tdata,
    // tuser: region
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import rcws_pkg::*;

    // config
    logic [31:0]           ceiling_color_reg;
    logic [31:0]           floor_color_reg;
    logic [ANGLE_BITS-1:0] view_angle_reg;
    logic [15:0]           proj_distance_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceiling_color_reg <= '0;
            floor_color_reg   <= '0;
            view_angle_reg    <= '0;
            proj_distance_reg <= 16'd887;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                CFG_CEILING: ceiling_color_reg <= pwdata;
                CFG_FLOOR:   floor_color_reg   <= pwdata;
                CFG_VIEW:    view_angle_reg    <= pwdata[ANGLE_BITS-1:0];
                CFG_PROJ:    proj_distance_reg <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            CFG_CEILING: prdata = ceiling_color_reg;
            CFG_FLOOR:   prdata = floor_color_reg;
            CFG_VIEW:    prdata = 32'(view_angle_reg);
            CFG_PROJ:    prdata = 32'(proj_distance_reg);
            default:     prdata = '0;
        endcase
    end

    // pipeline control
    logic adv;
    logic out_valid_reg;
    logic v9_reg;
    side_t s9_reg;

    assign adv           = !(out_valid_reg && !m_axis_tready && v9_reg && s9_reg.is_pix);
    assign s_axis_tready = adv;

    // input decode
    logic [9:0]            in_column;
    logic [8:0]            in_row;
    logic [DIST_W-1:0]     in_dist;
    logic [ANGLE_BITS-1:0] in_ray;
    logic [15:0]           in_coord;
    logic                  in_horiz;
    logic                  in_up;
    logic                  in_left;
    logic [TEX_AW-1:0]     in_tidx;
    logic [31:0]           in_tcolor;
    side_t                 in_side;
    logic [ANGLE_BITS-1:0] d_ang;
    logic [15:0]           a_ang;
    logic [14:0]           t_next;
    logic                  zero_next;

    assign in_column = s_axis_tdata[9:0];
    assign in_row    = s_axis_tdata[18:10];
    assign in_dist   = s_axis_tdata[42:19];
    assign in_ray    = s_axis_tdata[54:43];
    assign in_coord  = s_axis_tdata[70:55];
    assign in_horiz  = s_axis_tdata[71];
    assign in_up     = s_axis_tdata[72];
    assign in_left   = s_axis_tdata[73];
    assign in_tidx   = s_axis_tdata[87:74];
    assign in_tcolor = s_axis_tdata[119:88];

    always_comb
    begin
        in_side.is_pix  = s_axis_tuser;
        in_side.column  = in_column;
        in_side.row     = in_row;
        in_side.tex_sel = in_horiz ? (in_up ? 2'd0 : 2'd1) : (in_left ? 2'd2 : 2'd3);
        in_side.tex_x   = in_coord[TILE_BITS-1:0];
        in_side.waddr   = in_tidx;
        in_side.wdata   = in_tcolor;
    end

    assign d_ang     = in_ray - view_angle_reg;
    assign a_ang     = 16'({d_ang, {(16 - ANGLE_BITS){1'b0}}});
    assign zero_next = (a_ang[15:14] == 2'd1) || (a_ang[15:14] == 2'd2);
    assign t_next    = (a_ang[15:14] == 2'd3) ? (15'd16384 - 15'(a_ang[13:0]))
                                              : 15'(a_ang[13:0]);

    // cosine polynomial and perpendicular distance
    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    side_t             s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg, s7_reg;
    logic [DIST_W-1:0] d1_reg, d2_reg, d3_reg, d4_reg, d5_reg, d6_reg;
    logic              z1_reg, z2_reg, z3_reg, z4_reg, z5_reg;
    logic [14:0]       t1_reg;
    logic [14:0]       u2_reg, u2b_reg, u4_reg, u6_reg, u8_reg;
    logic [31:0]       p2_reg, p2b_reg;
    logic [29:0]       n4_reg, n4b_reg;
    logic [25:0]       p6_reg;
    logic [20:0]       n8_reg;
    logic [14:0]       cos_reg;
    logic [DIST_W-1:0] perp_reg;

    logic [29:0]       sq_t, sq_u2, m_u42, m_u44;
    logic [32:0]       pos_sum, neg_sum;
    logic [34:0]       diff;
    logic [17:0]       drop;
    logic [14:0]       cos_next;
    logic [38:0]       perp_prod;

    assign sq_t      = 30'(t1_reg) * 30'(t1_reg);
    assign sq_u2     = 30'(u2_reg) * 30'(u2_reg);
    assign m_u42     = 30'(u4_reg) * 30'(u2b_reg);
    assign m_u44     = 30'(u4_reg) * 30'(u4_reg);
    assign pos_sum   = 33'(p2b_reg) + 33'(p6_reg);
    assign neg_sum   = 33'(n4b_reg) + 33'(n8_reg);
    assign diff      = 35'(pos_sum) - 35'(neg_sum) + 35'd32768;
    assign drop      = diff[33:16];
    assign cos_next  = (z5_reg || diff[34] || (drop >= 18'd16384)) ? 15'd0
                                                                   : 15'(18'd16384 - drop);
    assign perp_prod = 39'(d6_reg) * 39'(cos_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg   <= in_side;
            d1_reg   <= in_dist;
            z1_reg   <= zero_next;
            t1_reg   <= t_next;

            s2_reg   <= s1_reg;
            d2_reg   <= d1_reg;
            z2_reg   <= z1_reg;
            u2_reg   <= sq_t[28:14];

            s3_reg   <= s2_reg;
            d3_reg   <= d2_reg;
            z3_reg   <= z2_reg;
            u2b_reg  <= u2_reg;
            u4_reg   <= sq_u2[28:14];

            s4_reg   <= s3_reg;
            d4_reg   <= d3_reg;
            z4_reg   <= z3_reg;
            u6_reg   <= m_u42[28:14];
            u8_reg   <= m_u44[28:14];
            p2_reg   <= 32'(u2b_reg) * 32'd80852;
            n4_reg   <= 30'(u4_reg) * 30'd16624;

            s5_reg   <= s4_reg;
            d5_reg   <= d4_reg;
            z5_reg   <= z4_reg;
            p6_reg   <= 26'(u6_reg) * 26'd1367;
            n8_reg   <= 21'(u8_reg) * 21'd60;
            n4b_reg  <= n4_reg;
            p2b_reg  <= p2_reg;

            s6_reg   <= s5_reg;
            d6_reg   <= d5_reg;
            cos_reg  <= cos_next;

            s7_reg   <= s6_reg;
            perp_reg <= perp_prod[37:14];
        end
    end

    // slice height
    logic [NUM_W-1:0]  num;
    logic [DIST_W-1:0] num_hi;
    logic              sat;
    logic              v8d;
    logic [DIST_W-1:0] quo1;
    logic [$bits(side_t):0] side8d;

    assign num    = NUM_W'(proj_distance_reg) << (TILE_BITS + 8);
    assign num_hi = DIST_W'(num[NUM_W-1:DIST_W]);
    assign sat    = (num_hi >= perp_reg);

    rcws_div #(
        .DEN_W  (DIST_W),
        .QUO_W  (DIST_W),
        .SIDE_W ($bits(side_t) + 1)
    ) u_div_height (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v7_reg),
        .in_rem    (num_hi),
        .in_low    (num[DIST_W-1:0]),
        .in_den    (perp_reg),
        .in_side   ({sat, s7_reg}),
        .out_valid (v8d),
        .out_quo   (quo1),
        .out_side  (side8d)
    );

    // row classification
    side_t             s8d;
    logic [DIST_W-1:0] height;
    logic [DIST_W-2:0] half;
    logic [DIST_W-1:0] row_half;
    region_t           region_next;

    assign s8d      = side8d[$bits(side_t)-1:0];
    assign height   = side8d[$bits(side_t)] ? HEIGHT_MAX : quo1;
    assign half     = height[DIST_W-1:1];
    assign row_half = DIST_W'(s8d.row) + DIST_W'(half);

    always_comb
    begin
        priority if (row_half < DIST_W'(MID_ROW))
        begin
            region_next = RGN_CEILING;
        end
        else if (DIST_W'(s8d.row) >= (DIST_W'(MID_ROW) + DIST_W'(half)))
        begin
            region_next = RGN_FLOOR;
        end
        else
        begin
            region_next = RGN_WALL;
        end
    end

    logic              v8_reg;
    side_t             s8_reg;
    region_t           rg8_reg;
    logic [DIST_W-1:0] dis_reg;
    logic [DIST_W-1:0] h8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg <= 1'b0;
        end
        else if (adv)
        begin
            v8_reg <= v8d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s8_reg  <= s8d;
            rg8_reg <= region_next;
            dis_reg <= row_half - DIST_W'(MID_ROW);
            h8_reg  <= height;
        end
    end

    // texel row
    logic                     v9d;
    logic [TILE_BITS-1:0]     ty;
    logic [$bits(side_t)+1:0] side9d;
    side_t                    s9d;
    logic [TEX_AW-1:0]        taddr;

    rcws_div #(
        .DEN_W  (DIST_W),
        .QUO_W  (TILE_BITS),
        .SIDE_W ($bits(side_t) + 2)
    ) u_div_texy (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v8_reg),
        .in_rem    (dis_reg),
        .in_low    ('0),
        .in_den    (h8_reg),
        .in_side   ({rg8_reg, s8_reg}),
        .out_valid (v9d),
        .out_quo   (ty),
        .out_side  (side9d)
    );

    assign s9d   = side9d[$bits(side_t)-1:0];
    assign taddr = s9d.is_pix ? TEX_AW'({s9d.tex_sel, ty, s9d.tex_x}) : s9d.waddr;

    // texel store
    logic [31:0] tex_mem [2**TEX_AW];
    logic [31:0] rdata_reg;
    region_t     rg9_reg;

    always_ff @(posedge clk)
    begin
        if (adv && v9d)
        begin
            if (s9d.is_pix)
            begin
                rdata_reg <= tex_mem[taddr];
            end
            else
            begin
                tex_mem[taddr] <= s9d.wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v9_reg <= 1'b0;
        end
        else if (adv)
        begin
            v9_reg <= v9d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s9_reg  <= s9d;
            rg9_reg <= region_t'(side9d[$bits(side_t)+1:$bits(side_t)]);
        end
    end

    // output register
    logic [31:0] color_next;
    logic [31:0] color_reg;
    region_t     region_reg;
    logic [9:0]  col_reg;
    logic [8:0]  row_reg;

    always_comb
    begin
        unique case (rg9_reg)
            RGN_CEILING: color_next = ceiling_color_reg;
            RGN_WALL:    color_next = rdata_reg;
            RGN_FLOOR:   color_next = floor_color_reg;
            default:     color_next = floor_color_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv && v9_reg && s9_reg.is_pix)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && v9_reg && s9_reg.is_pix)
        begin
            color_reg  <= color_next;
            region_reg <= rg9_reg;
            col_reg    <= s9_reg.column;
            row_reg    <= s9_reg.row;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, row_reg, col_reg, color_reg};
    assign m_axis_tuser  = region_reg;

endmodule
